FILE: hdl/dda_line_rasterizer_core_assert.svh
// Assertion macros shared by the checker of the line rasteriser.
`ifndef DDA_LINE_RASTERIZER_CORE_ASSERT_SVH
`define DDA_LINE_RASTERIZER_CORE_ASSERT_SVH

// The consequent must hold in the same cycle as the antecedent.
`define DDA_ASSERT_SAME(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
    else $error(msg);

// The consequent must hold in the cycle after the antecedent.
`define DDA_ASSERT_NEXT(label, clk, rst_n, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
    else $error(msg);

`endif

FILE: hdl/dda_pkg.sv
package dda_pkg;

  // Coordinate width; every width but COLOR_W follows from it.
  localparam int COORD_BITS = 16;
  // Deltas and division operands carry one extra bit.
  localparam int DELTA_W    = COORD_BITS + 1;
  // Minor coordinate before wrapping: origin plus running quotient.
  localparam int BASE_W     = COORD_BITS + 2;
  localparam int COLOR_W    = 32;
  localparam int DIV_CNT_W  = $clog2(DELTA_W + 1);

  // Stream word layouts, padded to whole bytes.
  localparam int IN_FIELDS_W  = 4 * COORD_BITS + COLOR_W;
  localparam int IN_DATA_W    = ((IN_FIELDS_W + 7) / 8) * 8;
  localparam int OUT_FIELDS_W = 2 * COORD_BITS + COLOR_W;
  localparam int OUT_DATA_W   = ((OUT_FIELDS_W + 7) / 8) * 8;

  localparam int X0_LSB    = 0;
  localparam int Y0_LSB    = COORD_BITS;
  localparam int X1_LSB    = 2 * COORD_BITS;
  localparam int Y1_LSB    = 3 * COORD_BITS;
  localparam int COLOR_LSB = 4 * COORD_BITS;

  // Values of the tuser selector on the input stream.
  localparam logic FUNC_LOAD = 1'b0;
  localparam logic FUNC_STEP = 1'b1;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic load;     // latch a new line and its operands
    logic step;     // emit the next pixel into the output register
    logic div_go;   // start the slope division
    logic commit;   // take the division result, line becomes active
  } dda_cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic load_zero;  // the offered load word describes a zero-length line
    logic active;     // a line is in progress
    logic out_full;   // the output register holds an untaken word
  } dda_sts_t;

endpackage

FILE: hdl/dda_line_rasterizer_core.sv
// Line rasteriser: walks a straight line one pixel per step word.
// Input stream (in_*): tuser selects the word kind. A load word (tuser 0)
// carries both endpoints and a colour; a step word (tuser 1) asks for the next
// pixel. The major axis is the one with the larger absolute delta, ties going
// to x, and the end pixel itself is never emitted.
// Output stream (out_*): one word per step word while a line is active, with
// tlast set on the final pixel. Step words with no active line are taken and
// dropped, and a zero-length load leaves no active line.
// Flow: a step word's pixel is registered and appears on the output in the cycle
// after the word is taken, and step words can be taken every cycle while the output
// register is not stalled. A load of non-zero length holds in_tready low while the
// bit-serial divider forms the slope magnitude, which the datapath turns into a floor
// quotient and remainder; a zero-length load does not hold in_tready low.
// Stalls: the pixel sits in an output register until out_tready; in_tready
// falls while that register is full and not being taken.
// Reset (rst_n low, synchronous) clears the controller, drops any line in
// progress and empties the output register.
module dda_line_rasterizer_core
  import dda_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  logic                  in_tvalid,
  output logic                  in_tready,
  // Fields from bit 0: start_x, start_y, end_x, end_y, line_color.
  input  logic [IN_DATA_W-1:0]  in_tdata,
  // Fields from bit 0: func.
  input  logic                  in_tuser,
  output logic                  out_tvalid,
  input  logic                  out_tready,
  // Fields from bit 0: pixel_x, pixel_y, pixel_color.
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  dda_cmd_t           cmd;
  dda_sts_t           sts;
  logic               div_done;
  logic [DELTA_W-1:0] div_dividend;
  logic [DELTA_W-1:0] div_divisor;
  logic [DELTA_W-1:0] div_quotient;
  logic [DELTA_W-1:0] div_remainder;

  // The controller sequences loads, divisions and pixel steps.
  dda_ctrl u_ctrl (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_func    (in_tuser),
    .out_tready (out_tready),
    .div_done   (div_done),
    .sts        (sts),
    .in_tready  (in_tready),
    .cmd        (cmd)
  );

  // The datapath holds the line state, the exact incremental slope and the
  // output register.
  dda_datapath u_datapath (
    .clk           (clk),
    .rst_n         (rst_n),
    .cmd           (cmd),
    .sts           (sts),
    .in_tdata      (in_tdata),
    .out_tready    (out_tready),
    .div_dividend  (div_dividend),
    .div_divisor   (div_divisor),
    .div_quotient  (div_quotient),
    .div_remainder (div_remainder),
    .out_tvalid    (out_tvalid),
    .out_tdata     (out_tdata),
    .out_tlast     (out_tlast)
  );

  // Restoring divider, one quotient bit per cycle.
  dda_div u_div (
    .clk       (clk),
    .rst_n     (rst_n),
    .start     (cmd.div_go),
    .dividend  (div_dividend),
    .divisor   (div_divisor),
    .done      (div_done),
    .quotient  (div_quotient),
    .remainder (div_remainder)
  );

endmodule

FILE: hdl/dda_div.sv
module dda_div
  import dda_pkg::*;
(
  input  logic               clk,
  input  logic               rst_n,
  input  logic               start,
  input  logic [DELTA_W-1:0] dividend,
  input  logic [DELTA_W-1:0] divisor,
  output logic               done,
  output logic [DELTA_W-1:0] quotient,
  output logic [DELTA_W-1:0] remainder
);

  logic [DIV_CNT_W-1:0] cnt_r, cnt_nxt;
  logic                 done_r, done_nxt;
  logic [DELTA_W-1:0]   quo_r, quo_nxt;
  logic [DELTA_W-1:0]   rem_r, rem_nxt;
  logic [DELTA_W:0]     shifted;
  logic [DELTA_W:0]     dsr_ext;
  logic [DELTA_W:0]     diff;
  logic                 ge;

  // One restoring step per cycle, most significant dividend bit first.
  assign shifted = {rem_r, quo_r[DELTA_W-1]};
  assign dsr_ext = {1'b0, divisor};
  assign diff    = shifted - dsr_ext;
  assign ge      = (shifted >= dsr_ext);

  always_comb begin
    cnt_nxt  = cnt_r;
    quo_nxt  = quo_r;
    rem_nxt  = rem_r;
    done_nxt = 1'b0;
    if (start) begin
      cnt_nxt = DIV_CNT_W'(DELTA_W);
      quo_nxt = dividend;
      rem_nxt = '0;
    end else if (cnt_r != '0) begin
      cnt_nxt  = cnt_r - DIV_CNT_W'(1);
      quo_nxt  = {quo_r[DELTA_W-2:0], ge};
      rem_nxt  = ge ? diff[DELTA_W-1:0] : shifted[DELTA_W-1:0];
      done_nxt = (cnt_r == DIV_CNT_W'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cnt_r  <= '0;
      done_r <= 1'b0;
    end else begin
      cnt_r  <= cnt_nxt;
      done_r <= done_nxt;
    end
    quo_r <= quo_nxt;
    rem_r <= rem_nxt;
  end

  assign done      = done_r;
  assign quotient  = quo_r;
  assign remainder = rem_r;

endmodule

FILE: hdl/dda_ctrl.sv
module dda_ctrl
  import dda_pkg::*;
(
  input  logic     clk,
  input  logic     rst_n,
  input  logic     in_tvalid,
  input  logic     in_func,
  input  logic     out_tready,
  input  logic     div_done,
  input  dda_sts_t sts,
  output logic     in_tready,
  output dda_cmd_t cmd
);

  localparam logic [1:0] S_READY   = 2'd0;
  localparam logic [1:0] S_DIVGO   = 2'd1;
  localparam logic [1:0] S_DIVWAIT = 2'd2;

  logic [1:0] state_r, state_nxt;
  logic       accept;

  // Words are taken only when the output register can receive a pixel.
  assign in_tready = (state_r == S_READY) && (!sts.out_full || out_tready);
  assign accept    = in_tvalid && in_tready;

  always_comb begin
    state_nxt  = state_r;
    cmd.load   = 1'b0;
    cmd.step   = 1'b0;
    cmd.div_go = 1'b0;
    cmd.commit = 1'b0;
    case (state_r)
      S_READY: begin
        if (accept && (in_func == FUNC_LOAD)) begin
          cmd.load = 1'b1;
          if (!sts.load_zero) begin
            state_nxt = S_DIVGO;
          end
        end else if (accept && (in_func == FUNC_STEP)) begin
          cmd.step = sts.active;
        end
      end
      S_DIVGO: begin
        cmd.div_go = 1'b1;
        state_nxt  = S_DIVWAIT;
      end
      S_DIVWAIT: begin
        if (div_done) begin
          cmd.commit = 1'b1;
          state_nxt  = S_READY;
        end
      end
      default: begin
        state_nxt = S_READY;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= S_READY;
    end else begin
      state_r <= state_nxt;
    end
  end

endmodule

FILE: hdl/dda_datapath.sv
module dda_datapath
  import dda_pkg::*;
(
  input  logic                  clk,
  input  logic                  rst_n,
  input  dda_cmd_t              cmd,
  output dda_sts_t              sts,
  input  logic [IN_DATA_W-1:0]  in_tdata,
  input  logic                  out_tready,
  output logic [DELTA_W-1:0]    div_dividend,
  output logic [DELTA_W-1:0]    div_divisor,
  input  logic [DELTA_W-1:0]    div_quotient,
  input  logic [DELTA_W-1:0]    div_remainder,
  output logic                  out_tvalid,
  output logic [OUT_DATA_W-1:0] out_tdata,
  output logic                  out_tlast
);

  // Line state.
  logic                  active_r, active_nxt;
  logic                  steep_r;
  logic                  sign_r;
  logic [COORD_BITS-1:0] pos_r;
  logic [COORD_BITS-1:0] stop_r;
  logic [COORD_BITS-1:0] origin_r;
  logic [DELTA_W-1:0]    span_r;
  logic [DELTA_W-1:0]    dmin_r;
  logic [DELTA_W-1:0]    whole_r;
  logic [DELTA_W-1:0]    part_r;
  logic [DELTA_W-1:0]    off_whole_r;
  logic [DELTA_W-1:0]    off_part_r;
  logic [COLOR_W-1:0]    color_r;

  // Output register.
  logic                  oval_r, oval_nxt;
  logic [COORD_BITS-1:0] ox_r, oy_r;
  logic [COLOR_W-1:0]    ocol_r;
  logic                  olast_r;

  // Load decode.
  logic [COORD_BITS-1:0] x0, y0, x1, y1;
  logic [DELTA_W-1:0]    dx, dy, adx, ady, dmaj, dmin;
  logic                  steep;

  assign x0 = in_tdata[X0_LSB +: COORD_BITS];
  assign y0 = in_tdata[Y0_LSB +: COORD_BITS];
  assign x1 = in_tdata[X1_LSB +: COORD_BITS];
  assign y1 = in_tdata[Y1_LSB +: COORD_BITS];

  assign dx    = {x1[COORD_BITS-1], x1} - {x0[COORD_BITS-1], x0};
  assign dy    = {y1[COORD_BITS-1], y1} - {y0[COORD_BITS-1], y0};
  assign adx   = dx[DELTA_W-1] ? -dx : dx;
  assign ady   = dy[DELTA_W-1] ? -dy : dy;
  assign steep = (ady > adx);
  assign dmaj  = steep ? dy : dx;
  assign dmin  = steep ? dx : dy;

  assign sts.load_zero = (dmaj == '0);
  assign sts.active    = active_r;
  assign sts.out_full  = oval_r;

  assign div_dividend = dmin_r[DELTA_W-1] ? -dmin_r : dmin_r;
  assign div_divisor  = span_r;

  // Pixel generation.
  logic [BASE_W-1:0]     base, minor;
  logic [COORD_BITS-1:0] next_pos;
  logic                  last;
  logic [DELTA_W:0]      part_sum;
  logic                  carry;

  assign base = {{(BASE_W-COORD_BITS){origin_r[COORD_BITS-1]}}, origin_r}
              + {{(BASE_W-DELTA_W){off_whole_r[DELTA_W-1]}}, off_whole_r};
  // Round toward zero: a negative value with a fractional part moves up by one.
  assign minor    = base + BASE_W'((off_part_r != '0) && base[BASE_W-1]);
  assign next_pos = sign_r ? pos_r - COORD_BITS'(1) : pos_r + COORD_BITS'(1);
  assign last     = (next_pos == stop_r);
  assign part_sum = {1'b0, off_part_r} + {1'b0, part_r};
  assign carry    = (part_sum >= {1'b0, span_r});

  always_comb begin
    active_nxt = active_r;
    if (cmd.load) begin
      active_nxt = 1'b0;
    end else if (cmd.commit) begin
      active_nxt = 1'b1;
    end else if (cmd.step && last) begin
      active_nxt = 1'b0;
    end
    oval_nxt = oval_r;
    if (cmd.step) begin
      oval_nxt = 1'b1;
    end else if (out_tready) begin
      oval_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r <= 1'b0;
      oval_r   <= 1'b0;
    end else begin
      active_r <= active_nxt;
      oval_r   <= oval_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      steep_r     <= steep;
      sign_r      <= dmaj[DELTA_W-1];
      pos_r       <= steep ? y0 : x0;
      stop_r      <= steep ? y1 : x1;
      origin_r    <= steep ? x0 : y0;
      span_r      <= dmaj[DELTA_W-1] ? -dmaj : dmaj;
      dmin_r      <= dmin;
      color_r     <= in_tdata[COLOR_LSB +: COLOR_W];
      off_whole_r <= '0;
      off_part_r  <= '0;
    end else if (cmd.step) begin
      pos_r       <= next_pos;
      off_part_r  <= carry ? DELTA_W'(part_sum - {1'b0, span_r}) : part_sum[DELTA_W-1:0];
      off_whole_r <= off_whole_r + whole_r + DELTA_W'(carry);
    end
    if (cmd.commit) begin
      // Turn the magnitude quotient into a floor quotient and remainder.
      if (dmin_r[DELTA_W-1] && (div_remainder != '0)) begin
        whole_r <= ~div_quotient;
        part_r  <= span_r - div_remainder;
      end else if (dmin_r[DELTA_W-1]) begin
        whole_r <= -div_quotient;
        part_r  <= '0;
      end else begin
        whole_r <= div_quotient;
        part_r  <= div_remainder;
      end
    end
    if (cmd.step) begin
      ox_r    <= steep_r ? minor[COORD_BITS-1:0] : pos_r;
      oy_r    <= steep_r ? pos_r : minor[COORD_BITS-1:0];
      ocol_r  <= color_r;
      olast_r <= last;
    end
  end

  assign out_tvalid = oval_r;
  assign out_tlast  = olast_r;
  assign out_tdata  = OUT_DATA_W'({ocol_r, oy_r, ox_r});

endmodule

FILE: hdl/dda_checker.sv
`include "dda_line_rasterizer_core_assert.svh"

module dda_checker
  import dda_pkg::*;
(
  input logic                  clk,
  input logic                  rst_n,
  input logic                  in_tvalid,
  input logic                  in_tready,
  input logic [IN_DATA_W-1:0]  in_tdata,
  input logic                  in_tuser,
  input logic                  out_tvalid,
  input logic                  out_tready,
  input logic [OUT_DATA_W-1:0] out_tdata,
  input logic                  out_tlast
);

  logic in_acc;
  logic load_long;

  assign in_acc    = in_tvalid && in_tready;
  assign load_long = in_acc && (in_tuser == FUNC_LOAD) &&
                     ((in_tdata[X0_LSB +: COORD_BITS] != in_tdata[X1_LSB +: COORD_BITS]) ||
                      (in_tdata[Y0_LSB +: COORD_BITS] != in_tdata[Y1_LSB +: COORD_BITS]));

  // A stalled pixel word holds.
  `DDA_ASSERT_NEXT(a_out_hold, clk, rst_n, out_tvalid && !out_tready, out_tvalid && $stable(out_tdata) && $stable(out_tlast), "output word changed while stalled")

  // A new pixel only follows a step word taken in the cycle before.
  `DDA_ASSERT_SAME(a_pixel_cause, clk, rst_n, $rose(out_tvalid), $past(in_acc && (in_tuser == FUNC_STEP)), "pixel without a step word")

  // A load never produces a pixel.
  `DDA_ASSERT_NEXT(a_load_silent, clk, rst_n, in_acc && (in_tuser == FUNC_LOAD), !$rose(out_tvalid), "pixel after a load word")

  // A load of non-zero length is followed by the division, with input held off.
  `DDA_ASSERT_NEXT(a_load_busy, clk, rst_n, load_long, !in_tready, "input taken during the slope division")

endmodule

bind dda_line_rasterizer_core dda_checker u_dda_checker (.*);
